@@ rtl/xxh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_pkg: shared types and constants of the XXH64 stream hash
// Holds the five XXH64 primes, the datapath operand and operation codes,
// and the command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  // Start value of lane 0; the sum wraps modulo 2^64.
  localparam logic [63:0] P1_P2 = P1 + P2;

  localparam int unsigned WORD_BYTES = 8;

  // Multiplier operand A source.
  typedef enum logic [2:0] {
    MA_BUF,
    MA_ACC,
    MA_T,
    MA_H,
    MA_LO32,
    MA_BYTE
  } ma_sel_t;

  // Multiplier operand B constant.
  typedef enum logic [1:0] {
    MB_P1,
    MB_P2,
    MB_P3,
    MB_P5
  } mb_sel_t;

  // Operation applied to the registered product or the working registers.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_RND_PRE,
    OP_ACC_WR,
    OP_MRG0,
    OP_MRG1,
    OP_MRG2,
    OP_SHORT,
    OP_ROT31_T,
    OP_XOR_P,
    OP_P_ADD4,
    OP_ADDLEN,
    OP_XROT27,
    OP_XROT23,
    OP_P_ADD3_SH32,
    OP_XROT11,
    OP_P_SH8,
    OP_FOLD33,
    OP_FOLD29,
    OP_EMIT
  } alu_op_t;

  typedef struct packed {
    logic       accept;
    logic       new_msg;
    logic [3:0] n;
    logic       buf_wr;
    logic [1:0] idx;
    ma_sel_t    ma_sel;
    mb_sel_t    mb_sel;
    alu_op_t    op;
  } xxh_cmd_t;

endpackage

@@ rtl/xxh64_stream_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_stream_hash: streaming 64-bit xxHash (XXH64) of a word stream
// Top level: controller, datapath and the configuration port.
// ----------------------------------------------------------------------------
// Usage. A message arrives as 64-bit words, first byte in bits 7:0. A word
// transfers at a rising edge with start high and busy low. Every word but the
// last carries eight bytes; the last carries in_byte_count bytes (0 to 8, a
// larger count counts as eight) and has in_last_word set.
// A word other than the last that does not complete a 32-byte stripe is
// taken while busy stays low. A word that completes a stripe holds busy while
// four lanes each run two multiply steps on the shared two-stage multiplier.
// After the last word the block finishes the hash: the short-message start
// or, for a message of 32 bytes or more, the lane merge, then a fold per
// buffered tail word, a four-byte tail step and a step per tail byte. The
// result is on out_hash_value with out_valid high for one cycle, in the cycle
// in which busy falls; the receiver cannot stall it.
// The seed is written through cfg_valid/cfg_ready (always ready); the user is
// to write it only while the block is idle (the block does not enforce this),
// and it is taken at the first word of the next message. Reset clears the
// seed to zero and closes any open message; no clearing pass is needed.
// ----------------------------------------------------------------------------
module xxh64_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  output logic [63:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed
);
  import xxh_pkg::*;

  xxh_cmd_t cmd;
  logic     dp_long;
  logic     cfg_wr;

  // The seed register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  xxh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .dp_long       (dp_long),
    .busy          (busy),
    .cmd           (cmd)
  );

  xxh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_wr),
    .cfg_seed       (cfg_seed),
    .in_data_word   (in_data_word),
    .cmd            (cmd),
    .dp_long        (dp_long),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value)
  );

endmodule

@@ rtl/xxh_mul64.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_mul64: two-stage 64 x 64 multiplier, low 64 bits of the product
// Stage one forms three 32 x 32 partial products; stage two adds the cross
// terms into the upper half. The partial products and the product are
// each registered.
// ----------------------------------------------------------------------------
module xxh_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p_r
);

  logic [63:0] ll_nxt;
  logic [63:0] ll_r;
  logic [31:0] lh_nxt;
  logic [31:0] lh_r;
  logic [31:0] hl_nxt;
  logic [31:0] hl_r;

  assign ll_nxt = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  // Only the low half of each cross term reaches the result.
  assign lh_nxt = a[31:0] * b[63:32];
  assign hl_nxt = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    ll_r <= ll_nxt;
    lh_r <= lh_nxt;
    hl_r <= hl_nxt;
    p_r  <= {ll_r[63:32] + lh_r + hl_r, ll_r[31:0]};
  end

endmodule

@@ rtl/xxh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_dp: XXH64 datapath
// Holds the seed, the four lane accumulators, the stripe buffer, the length
// counter and the working registers, and runs one operation per command.
// ----------------------------------------------------------------------------
module xxh_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic [63:0]      cfg_seed,
  input  logic [63:0]      in_data_word,
  input  xxh_pkg::xxh_cmd_t cmd,
  output logic             dp_long,
  output logic             out_valid,
  output logic [63:0]      out_hash_value
);
  import xxh_pkg::*;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  logic [63:0] seed_r;
  logic [63:0] total_r;
  logic        out_valid_r;
  logic [63:0] hash_r;
  logic [63:0] acc_r [4];
  logic [63:0] buf_r [4];
  logic [63:0] h_r;
  logic [63:0] h_nxt;
  logic [63:0] t_r;
  logic [63:0] t_nxt;
  logic [63:0] word_r;
  logic [63:0] word_nxt;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] prod;

  xxh_mul64 u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  always_comb begin
    unique case (cmd.ma_sel)
      MA_BUF:  mul_a = buf_r[cmd.idx];
      MA_ACC:  mul_a = acc_r[cmd.idx];
      MA_T:    mul_a = t_r;
      MA_H:    mul_a = h_r;
      MA_LO32: mul_a = {32'd0, word_r[31:0]};
      MA_BYTE: mul_a = {56'd0, word_r[7:0]};
      default: mul_a = h_r;
    endcase
    unique case (cmd.mb_sel)
      MB_P1:   mul_b = P1;
      MB_P2:   mul_b = P2;
      MB_P3:   mul_b = P3;
      MB_P5:   mul_b = P5;
      default: mul_b = P1;
    endcase
  end

  always_comb begin
    h_nxt    = h_r;
    t_nxt    = t_r;
    word_nxt = cmd.accept ? in_data_word : word_r;
    unique case (cmd.op)
      OP_NONE:        h_nxt = h_r;
      OP_RND_PRE:     h_nxt = rotl(acc_r[cmd.idx] + prod, 31);
      OP_ACC_WR:      h_nxt = h_r;
      OP_MRG0:        h_nxt = rotl(acc_r[0], 1) + rotl(acc_r[1], 7);
      OP_MRG1:        h_nxt = h_r + rotl(acc_r[2], 12);
      OP_MRG2:        h_nxt = h_r + rotl(acc_r[3], 18);
      OP_SHORT:       h_nxt = acc_r[2] + P5;
      OP_ROT31_T:     t_nxt = rotl(prod, 31);
      OP_XOR_P:       h_nxt = h_r ^ prod;
      OP_P_ADD4:      h_nxt = prod + P4;
      OP_ADDLEN:      h_nxt = h_r + total_r;
      OP_XROT27:      h_nxt = rotl(h_r ^ prod, 27);
      OP_XROT23:      h_nxt = rotl(h_r ^ prod, 23);
      OP_P_ADD3_SH32: begin
        h_nxt    = prod + P3;
        word_nxt = word_r >> 32;
      end
      OP_XROT11:      h_nxt = rotl(h_r ^ prod, 11);
      OP_P_SH8: begin
        h_nxt    = prod;
        word_nxt = word_r >> 8;
      end
      OP_FOLD33:      h_nxt = h_r ^ (h_r >> 33);
      OP_FOLD29:      h_nxt = prod ^ (prod >> 29);
      OP_EMIT:        h_nxt = h_r;
      default:        h_nxt = h_r;
    endcase
  end

  // Control state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        seed_r <= cfg_seed;
      end
      if (cmd.accept) begin
        total_r <= (cmd.new_msg ? 64'd0 : total_r) + {60'd0, cmd.n};
      end
      out_valid_r <= (cmd.op == OP_EMIT);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    t_r    <= t_nxt;
    word_r <= word_nxt;
    if (cmd.accept && cmd.buf_wr) begin
      buf_r[cmd.idx] <= in_data_word;
    end
    if (cmd.accept && cmd.new_msg) begin
      acc_r[0] <= seed_r + P1_P2;
      acc_r[1] <= seed_r + P2;
      acc_r[2] <= seed_r;
      acc_r[3] <= seed_r - P1;
    end
    if (cmd.op == OP_ACC_WR) begin
      acc_r[cmd.idx] <= prod;
    end
    if (cmd.op == OP_EMIT) begin
      hash_r <= prod ^ (prod >> 32);
    end
  end

  // A message of 32 bytes or more takes the merged-lane path.
  assign dp_long        = |total_r[63:5];
  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

@@ rtl/xxh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_ctrl: XXH64 sequencer
// Takes input words, tracks the stripe fill and the tail, and steps the
// datapath through lane rounds, the merge, the tail folds and the avalanche.
// ----------------------------------------------------------------------------
module xxh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [3:0]        in_byte_count,
  input  logic              in_last_word,
  input  logic              dp_long,
  output logic              busy,
  output xxh_pkg::xxh_cmd_t cmd
);
  import xxh_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RND_A,
    ST_RND_B,
    ST_FIN_BEGIN,
    ST_MRG1,
    ST_MRG2,
    ST_MG_A,
    ST_MG_B,
    ST_MG_C,
    ST_ADDLEN,
    ST_TW_A,
    ST_TW_B,
    ST_TW_C,
    ST_T4_A,
    ST_T4_B,
    ST_TB_A,
    ST_TB_B,
    ST_FX33,
    ST_FX_A,
    ST_FX_B
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  logic [1:0]  ph_r;
  logic [1:0]  ph_nxt;
  logic [1:0]  idx_r;
  logic [1:0]  idx_nxt;
  logic [1:0]  bw_r;
  logic [1:0]  bw_nxt;
  logic [2:0]  part_r;
  logic [2:0]  part_nxt;
  logic        last_r;
  logic        last_nxt;
  logic        open_r;
  logic        open_nxt;

  logic [3:0]  cnt;
  logic [3:0]  n;
  logic        full;
  logic [1:0]  bw_cur;
  logic        step_done;
  logic        mul_st;
  alu_op_t     mul_op;

  // Where the fold of the partial last word begins.
  function automatic state_t tail_next(input logic [2:0] part);
    if (part >= 3'd4) begin
      return ST_T4_A;
    end else if (part != 3'd0) begin
      return ST_TB_A;
    end
    return ST_FX33;
  endfunction

  assign cnt       = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
  assign n         = in_last_word ? cnt : 4'(WORD_BYTES);
  assign full      = (n == 4'(WORD_BYTES));
  assign bw_cur    = open_r ? bw_r : 2'd0;
  assign step_done = (ph_r == 2'd2);
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = 2'd0;
    idx_nxt    = idx_r;
    bw_nxt     = bw_r;
    part_nxt   = part_r;
    last_nxt   = last_r;
    open_nxt   = open_r;
    mul_st     = 1'b0;
    mul_op     = OP_NONE;
    cmd        = '0;
    cmd.idx    = idx_r;
    cmd.ma_sel = MA_H;
    cmd.mb_sel = MB_P1;
    cmd.op     = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept  = 1'b1;
          cmd.new_msg = !open_r;
          cmd.n       = n;
          cmd.buf_wr  = full;
          cmd.idx     = bw_cur;
          part_nxt    = full ? 3'd0 : n[2:0];
          last_nxt    = in_last_word;
          open_nxt    = !in_last_word;
          idx_nxt     = 2'd0;
          if (full) begin
            bw_nxt = bw_cur + 2'd1;
          end else begin
            bw_nxt = bw_cur;
          end
          if (full && bw_cur == 2'd3) begin
            state_nxt = ST_RND_A;
          end else if (in_last_word) begin
            state_nxt = ST_FIN_BEGIN;
          end
        end
      end
      ST_RND_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_BUF;
        cmd.mb_sel = MB_P2;
        mul_op     = OP_RND_PRE;
        if (step_done) begin
          state_nxt = ST_RND_B;
        end
      end
      ST_RND_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_ACC_WR;
        if (step_done) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            state_nxt = last_r ? ST_FIN_BEGIN : ST_IDLE;
          end else begin
            state_nxt = ST_RND_A;
          end
        end
      end
      ST_FIN_BEGIN: begin
        idx_nxt = 2'd0;
        if (dp_long) begin
          cmd.op    = OP_MRG0;
          state_nxt = ST_MRG1;
        end else begin
          cmd.op    = OP_SHORT;
          state_nxt = ST_ADDLEN;
        end
      end
      ST_MRG1: begin
        cmd.op    = OP_MRG1;
        state_nxt = ST_MRG2;
      end
      ST_MRG2: begin
        cmd.op    = OP_MRG2;
        state_nxt = ST_MG_A;
      end
      ST_MG_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_ACC;
        cmd.mb_sel = MB_P2;
        mul_op     = OP_ROT31_T;
        if (step_done) begin
          state_nxt = ST_MG_B;
        end
      end
      ST_MG_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_T;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_XOR_P;
        if (step_done) begin
          state_nxt = ST_MG_C;
        end
      end
      ST_MG_C: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_P_ADD4;
        if (step_done) begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? ST_ADDLEN : ST_MG_A;
        end
      end
      ST_ADDLEN: begin
        cmd.op    = OP_ADDLEN;
        idx_nxt   = 2'd0;
        state_nxt = (bw_r != 2'd0) ? ST_TW_A : tail_next(part_r);
      end
      ST_TW_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_BUF;
        cmd.mb_sel = MB_P2;
        mul_op     = OP_ROT31_T;
        if (step_done) begin
          state_nxt = ST_TW_B;
        end
      end
      ST_TW_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_T;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_XROT27;
        if (step_done) begin
          state_nxt = ST_TW_C;
        end
      end
      ST_TW_C: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_P_ADD4;
        if (step_done) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r + 2'd1 == bw_r) begin
            state_nxt = tail_next(part_r);
          end else begin
            state_nxt = ST_TW_A;
          end
        end
      end
      ST_T4_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_LO32;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_XROT23;
        if (step_done) begin
          state_nxt = ST_T4_B;
        end
      end
      ST_T4_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P2;
        mul_op     = OP_P_ADD3_SH32;
        if (step_done) begin
          part_nxt  = part_r - 3'd4;
          state_nxt = (part_r != 3'd4) ? ST_TB_A : ST_FX33;
        end
      end
      ST_TB_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_BYTE;
        cmd.mb_sel = MB_P5;
        mul_op     = OP_XROT11;
        if (step_done) begin
          state_nxt = ST_TB_B;
        end
      end
      ST_TB_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P1;
        mul_op     = OP_P_SH8;
        if (step_done) begin
          part_nxt  = part_r - 3'd1;
          state_nxt = (part_r == 3'd1) ? ST_FX33 : ST_TB_A;
        end
      end
      ST_FX33: begin
        cmd.op    = OP_FOLD33;
        state_nxt = ST_FX_A;
      end
      ST_FX_A: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P2;
        mul_op     = OP_FOLD29;
        if (step_done) begin
          state_nxt = ST_FX_B;
        end
      end
      ST_FX_B: begin
        mul_st     = 1'b1;
        cmd.ma_sel = MA_H;
        cmd.mb_sel = MB_P3;
        mul_op     = OP_EMIT;
        if (step_done) begin
          bw_nxt    = 2'd0;
          part_nxt  = 3'd0;
          open_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Multiply steps: issue, wait for the product, then apply the operation.
    if (mul_st) begin
      ph_nxt = step_done ? 2'd0 : ph_r + 2'd1;
      if (step_done) begin
        cmd.op = mul_op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= 2'd0;
      idx_r   <= 2'd0;
      bw_r    <= 2'd0;
      part_r  <= 3'd0;
      last_r  <= 1'b0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      bw_r    <= bw_nxt;
      part_r  <= part_nxt;
      last_r  <= last_nxt;
      open_r  <= open_nxt;
    end
  end

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_word) |=> busy)
    else $error("last word did not start the finish sequence");

  a_plain_word_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_word && bw_cur != 2'd3) |=> !busy)
    else $error("word that completes no stripe left the block busy");

  a_tail_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TW_A) |-> (idx_r < bw_r))
    else $error("tail word index beyond the buffered words");

  a_close_message: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FX_B && step_done) |=>
      (state_r == ST_IDLE && !open_r && bw_r == 2'd0))
    else $error("message not closed after the result");

endmodule
